>>> rtl/corexy_stepper_pulse_mover_assert.svh
// Assertion macros used by the step core of the step pulse mover RTL.
`ifndef COREXY_STEPPER_PULSE_MOVER_ASSERT_SVH
`define COREXY_STEPPER_PULSE_MOVER_ASSERT_SVH

// Same-cycle implication, reset held off.
`define CXY_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset held off.
`define CXY_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cxy_pkg.sv
// Shared types and constants of the CoreXY step pulse mover.
`timescale 1ns / 1ps
package cxy_pkg;

  localparam int POS_W  = 32;
  localparam int SIZE_W = 16;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_ZERO = 2'd2,
    ACT_NOP  = 2'd3
  } cxy_action_e;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_OK   = 2'd1,
    ST_OOB  = 2'd2,
    ST_BUSY = 2'd3
  } cxy_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cxy_cfg_idx_e;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } cxy_cfg_t;

  typedef struct packed {
    logic              step_a;
    logic              step_b;
    logic              step_z;
    logic              dir_a;
    logic              dir_b;
    logic              dir_z;
    logic              busy_res;
    cxy_status_e       status;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
  } cxy_res_t;

endpackage

>>> rtl/cxy_in_if.sv
// Request channel: action and move fields with valid/ready.
`timescale 1ns / 1ps
interface cxy_in_if #(
  parameter int MOVE_WIDTH  = 16,
  parameter int DELAY_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic signed [MOVE_WIDTH-1:0]  move_x;
  logic signed [MOVE_WIDTH-1:0]  move_y;
  logic signed [MOVE_WIDTH-1:0]  move_z;
  logic [DELAY_WIDTH-1:0]        half_period;
  logic                          ignore_bounds;

  modport source (
    output valid, action, move_x, move_y, move_z, half_period, ignore_bounds,
    input  ready
  );
  modport sink (
    input  valid, action, move_x, move_y, move_z, half_period, ignore_bounds,
    output ready
  );
endinterface

>>> rtl/cxy_out_if.sv
// Result channel: step/dir levels, status and position with valid/ready.
`timescale 1ns / 1ps
interface cxy_out_if;
  logic               valid;
  logic               ready;
  logic               step_a;
  logic               step_b;
  logic               step_z;
  logic               dir_a;
  logic               dir_b;
  logic               dir_z;
  logic               busy_res;
  logic [1:0]         status;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (
    output valid, step_a, step_b, step_z, dir_a, dir_b, dir_z, busy_res, status,
           pos_x, pos_y, pos_z,
    input  ready
  );
  modport sink (
    input  valid, step_a, step_b, step_z, dir_a, dir_b, dir_z, busy_res, status,
           pos_x, pos_y, pos_z,
    output ready
  );
endinterface

>>> rtl/corexy_stepper_pulse_mover.sv
// Top level of the CoreXY step pulse mover: config registers, stages, result register.
//
//   channel | dir | handshake      | payload
//   req_i   | in  | valid/ready    | action, move_x/y/z, half_period, ignore_bounds
//   res_o   | out | valid/ready    | step/dir a,b,z, busy_res, status, pos_x/y/z
//   cfg     | in  | cfg_we_i only  | cfg_idx_i, cfg_data_i
//
// One request per clock unless stalled; its result is held in the result register.
// The whole update of the motion state is one pass of logic from the input register.
// rst_ni clears the motion state, stage valids and sets all sizes to 65535.
// A stalled result register holds the input register, which then drops ready.
`timescale 1ns / 1ps
module corexy_stepper_pulse_mover #(
  parameter int MOVE_WIDTH  = 16,
  parameter int DELAY_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cxy_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cxy_pkg::CFG_W-1:0]          cfg_data_i,
  cxy_in_if.sink                             req_i,
  cxy_out_if.source                          res_o
);
  import cxy_pkg::*;

  logic                          s1_valid;
  logic                          advance;
  logic [1:0]                    s1_action;
  logic signed [MOVE_WIDTH-1:0]  s1_move_x, s1_move_y, s1_move_z;
  logic [DELAY_WIDTH-1:0]        s1_half_period;
  logic                          s1_ignore_bounds;
  cxy_cfg_t                      cfg_q;
  cxy_res_t                      res_d, res_q;
  logic                          out_valid_q;

  // Size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x <= SIZE_RESET;
      cfg_q.size_y <= SIZE_RESET;
      cfg_q.size_z <= SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cxy_cfg_idx_e'(cfg_idx_i))
        CFG_SIZE_X: cfg_q.size_x <= cfg_data_i[SIZE_W-1:0];
        CFG_SIZE_Y: cfg_q.size_y <= cfg_data_i[SIZE_W-1:0];
        CFG_SIZE_Z: cfg_q.size_z <= cfg_data_i[SIZE_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Process the held request when the result register has room
  assign advance = s1_valid && (!out_valid_q || res_o.ready);

  cxy_in_reg #(
    .MOVE_WIDTH  (MOVE_WIDTH),
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_in_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_i),
    .take_i          (advance),
    .valid_o         (s1_valid),
    .action_o        (s1_action),
    .move_x_o        (s1_move_x),
    .move_y_o        (s1_move_y),
    .move_z_o        (s1_move_z),
    .half_period_o   (s1_half_period),
    .ignore_bounds_o (s1_ignore_bounds)
  );

  cxy_step_core #(
    .MOVE_WIDTH  (MOVE_WIDTH),
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (advance),
    .action_i        (s1_action),
    .move_x_i        (s1_move_x),
    .move_y_i        (s1_move_y),
    .move_z_i        (s1_move_z),
    .half_period_i   (s1_half_period),
    .ignore_bounds_i (s1_ignore_bounds),
    .cfg_i           (cfg_q),
    .res_o           (res_d)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || res_o.ready) begin
      out_valid_q <= s1_valid;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.step_a   = res_q.step_a;
  assign res_o.step_b   = res_q.step_b;
  assign res_o.step_z   = res_q.step_z;
  assign res_o.dir_a    = res_q.dir_a;
  assign res_o.dir_b    = res_q.dir_b;
  assign res_o.dir_z    = res_q.dir_z;
  assign res_o.busy_res = res_q.busy_res;
  assign res_o.status   = res_q.status;
  assign res_o.pos_x    = res_q.pos_x;
  assign res_o.pos_y    = res_q.pos_y;
  assign res_o.pos_z    = res_q.pos_z;

endmodule

>>> rtl/cxy_in_reg.sv
// Input register stage: captures one request and holds it until taken.
`timescale 1ns / 1ps
module cxy_in_reg #(
  parameter int MOVE_WIDTH  = 16,
  parameter int DELAY_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cxy_in_if.sink                        req_i,
  input  logic                          take_i,
  output logic                          valid_o,
  output logic [1:0]                    action_o,
  output logic signed [MOVE_WIDTH-1:0]  move_x_o,
  output logic signed [MOVE_WIDTH-1:0]  move_y_o,
  output logic signed [MOVE_WIDTH-1:0]  move_z_o,
  output logic [DELAY_WIDTH-1:0]        half_period_o,
  output logic                          ignore_bounds_o
);

  logic valid_q;
  logic accept;

  // Accept when empty or when the held request is being taken
  assign req_i.ready = !valid_q || take_i;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_o        <= req_i.action;
      move_x_o        <= req_i.move_x;
      move_y_o        <= req_i.move_y;
      move_z_o        <= req_i.move_z;
      half_period_o   <= req_i.half_period;
      ignore_bounds_o <= req_i.ignore_bounds;
    end
  end

  assign valid_o = valid_q;

endmodule

>>> rtl/cxy_step_core.sv
// Motion state and next-state logic: move check, CoreXY mix, pulse timing.
`timescale 1ns / 1ps
module cxy_step_core #(
  parameter int MOVE_WIDTH  = 16,
  parameter int DELAY_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [1:0]                    action_i,
  input  logic signed [MOVE_WIDTH-1:0]  move_x_i,
  input  logic signed [MOVE_WIDTH-1:0]  move_y_i,
  input  logic signed [MOVE_WIDTH-1:0]  move_z_i,
  input  logic [DELAY_WIDTH-1:0]        half_period_i,
  input  logic                          ignore_bounds_i,
  input  cxy_pkg::cxy_cfg_t             cfg_i,
  output cxy_pkg::cxy_res_t             res_o
);
  import cxy_pkg::*;
  `include "corexy_stepper_pulse_mover_assert.svh"

  localparam int MW = MOVE_WIDTH;
  localparam int DW = DELAY_WIDTH;
  localparam int SW = MOVE_WIDTH + 2;

  logic [MW:0]              left_a_q, left_a_d, left_a_dec;
  logic [MW:0]              left_b_q, left_b_d, left_b_dec;
  logic [MW-1:0]            left_z_q, left_z_d, left_z_dec;
  logic [2:0]               dir_q, dir_d;
  logic                     pulse_q, pulse_d;
  logic [DW-1:0]            pc_q, pc_d, pc_inc;
  logic [DW-1:0]            pl_q, pl_d;
  logic [2:0][POS_W-1:0]    pos_q, pos_d;
  logic [2:0][POS_W-1:0]    tgt_q, tgt_d;
  logic [2:0][POS_W-1:0]    tgt_new;
  logic [2:0]               in_bnd;
  logic signed [SW-1:0]     dx_s, dy_s, dz_s, a_s, b_s;
  logic [SW-1:0]            a_mag, b_mag, z_mag;
  logic                     busy, busy_dec, busy_new, bounds_ok;
  cxy_status_e              status;

  // Remaining-step view of the state
  assign busy       = (|left_a_q) || (|left_b_q) || (|left_z_q);
  assign left_a_dec = left_a_q - {{MW{1'b0}}, |left_a_q};
  assign left_b_dec = left_b_q - {{MW{1'b0}}, |left_b_q};
  assign left_z_dec = left_z_q - {{(MW-1){1'b0}}, |left_z_q};
  assign busy_dec   = (|left_a_dec) || (|left_b_dec) || (|left_z_dec);
  assign pc_inc     = pc_q + {{(DW-1){1'b0}}, 1'b1};

  // Motor step counts: a = -(dy + dx), b = dy - dx, z = dz
  assign dx_s  = SW'(move_x_i);
  assign dy_s  = SW'(move_y_i);
  assign dz_s  = SW'(move_z_i);
  assign a_s   = -(dy_s + dx_s);
  assign b_s   = dy_s - dx_s;
  assign a_mag = a_s[SW-1] ? SW'(-a_s) : SW'(a_s);
  assign b_mag = b_s[SW-1] ? SW'(-b_s) : SW'(b_s);
  assign z_mag = dz_s[SW-1] ? SW'(-dz_s) : SW'(dz_s);
  assign busy_new = (|a_mag) || (|b_mag) || (|z_mag);

  // Target positions, wrapping in 32 bits
  assign tgt_new[0] = pos_q[0] + POS_W'(move_x_i);
  assign tgt_new[1] = pos_q[1] + POS_W'(move_y_i);
  assign tgt_new[2] = pos_q[2] + POS_W'(move_z_i);

  // Target must lie in 0..size as a signed value
  assign in_bnd[0] = (tgt_new[0][POS_W-1:SIZE_W] == '0) &&
                     (tgt_new[0][SIZE_W-1:0] <= cfg_i.size_x);
  assign in_bnd[1] = (tgt_new[1][POS_W-1:SIZE_W] == '0) &&
                     (tgt_new[1][SIZE_W-1:0] <= cfg_i.size_y);
  assign in_bnd[2] = (tgt_new[2][POS_W-1:SIZE_W] == '0) &&
                     (tgt_new[2][SIZE_W-1:0] <= cfg_i.size_z);
  assign bounds_ok = ignore_bounds_i || (&in_bnd);

  // Apply one request to the state
  always_comb begin
    left_a_d = left_a_q;
    left_b_d = left_b_q;
    left_z_d = left_z_q;
    dir_d    = dir_q;
    pulse_d  = pulse_q;
    pc_d     = pc_q;
    pl_d     = pl_q;
    pos_d    = pos_q;
    tgt_d    = tgt_q;
    status   = ST_NONE;
    case (cxy_action_e'(action_i))
      ACT_TICK: begin
        if (busy) begin
          if (pc_inc != pl_q) begin
            pc_d = pc_inc;
          end else begin
            pc_d = '0;
            if (pulse_q) begin
              pulse_d = 1'b0;
            end else begin
              left_a_d = left_a_dec;
              left_b_d = left_b_dec;
              left_z_d = left_z_dec;
              if (busy_dec) begin
                pulse_d = 1'b1;
              end else begin
                pos_d   = tgt_q;
                pulse_d = 1'b0;
              end
            end
          end
        end
      end
      ACT_MOVE: begin
        if (busy) begin
          status = ST_BUSY;
        end else if (!bounds_ok) begin
          status = ST_OOB;
        end else begin
          status   = ST_OK;
          tgt_d    = tgt_new;
          dir_d    = {!dz_s[SW-1], !b_s[SW-1], !a_s[SW-1]};
          left_a_d = a_mag[MW:0];
          left_b_d = b_mag[MW:0];
          left_z_d = z_mag[MW-1:0];
          pl_d     = (half_period_i == '0) ? {{(DW-1){1'b0}}, 1'b1} : half_period_i;
          pc_d     = '0;
          if (busy_new) begin
            pulse_d = 1'b1;
          end else begin
            pos_d   = tgt_new;
            pulse_d = 1'b0;
          end
        end
      end
      ACT_ZERO: begin
        if (busy) begin
          status = ST_BUSY;
        end else begin
          pos_d = '0;
          tgt_d = '0;
        end
      end
      ACT_NOP: begin
        status = ST_NONE;
      end
      default: begin
        status = ST_NONE;
      end
    endcase
  end

  // Result reflects the state after the request
  always_comb begin
    res_o.step_a   = pulse_d && (|left_a_d);
    res_o.step_b   = pulse_d && (|left_b_d);
    res_o.step_z   = pulse_d && (|left_z_d);
    res_o.dir_a    = dir_d[0];
    res_o.dir_b    = dir_d[1];
    res_o.dir_z    = dir_d[2];
    res_o.busy_res = (|left_a_d) || (|left_b_d) || (|left_z_d);
    res_o.status   = status;
    res_o.pos_x    = pos_d[0];
    res_o.pos_y    = pos_d[1];
    res_o.pos_z    = pos_d[2];
  end

  // Commit the state when a request is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_a_q <= '0;
      left_b_q <= '0;
      left_z_q <= '0;
      dir_q    <= '0;
      pulse_q  <= 1'b0;
      pc_q     <= '0;
      pl_q     <= '0;
      pos_q    <= '0;
      tgt_q    <= '0;
    end else if (fire_i) begin
      left_a_q <= left_a_d;
      left_b_q <= left_b_d;
      left_z_q <= left_z_d;
      dir_q    <= dir_d;
      pulse_q  <= pulse_d;
      pc_q     <= pc_d;
      pl_q     <= pl_d;
      pos_q    <= pos_d;
      tgt_q    <= tgt_d;
    end
  end

  `CXY_ASSERT_IMPL(a_busy_len, clk_i, rst_ni, busy, pl_q != '0, "busy with zero phase length")
  `CXY_ASSERT_IMPL(a_idle_quiet, clk_i, rst_ni, !busy, !pulse_q && (pc_q == '0),
                   "pulse timing active while idle")
  `CXY_ASSERT_NEXT(a_busy_hold, clk_i, rst_ni, !fire_i && busy, busy,
                   "step count changed without a request")

endmodule
